@@ hw/rtl/rvl_pkg.sv @@
package rvl_pkg;

  localparam int TGT_W      = 31;
  localparam int TGT_SHIFT  = 20;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 15;
  localparam int CLR_W      = 16;
  localparam int CYC_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic [TGT_W-1:0] TGT_MAX  = '1;
  localparam logic [CLR_W-1:0] CLR_NONE = '1;
  localparam logic [CYC_W-1:0] CYC_MAX  = '1;

  localparam status_t ST_RUNNING      = 3'd0;
  localparam status_t ST_SUCCEEDED    = 3'd1;
  localparam status_t ST_TIMEOUT      = 3'd2;
  localparam status_t ST_NO_FOOTPRINT = 3'd3;
  localparam status_t ST_NO_SCAN      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

  localparam logic [GAIN_W-1:0]  RST_FORCE_GAIN = 16'd6554;
  localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = 15'd1024;
  localparam logic [SPEED_W-1:0] RST_ACCEL_STEP = 15'd205;
  localparam logic [CLR_W-1:0]   RST_CLR_THRESH = 16'd1434;
  localparam logic [CYC_W-1:0]   RST_TIMEOUT    = 16'd600;

endpackage

@@ hw/rtl/repulsive_velocity_limiter.sv @@
// Escape velocity limiter: turns a net repulsive force into a planar velocity command.
// Input channel (in_*): one word per request. in_tuser is the request kind, 0 starts a
// run and 1 is a control cycle. Result channel (out_*): exactly one word per request.
// Configuration channel (cfg_*): register writes, always ready; write only while no
// request is in flight.
// A start request or a control cycle that ends early (timeout, missing footprint, scan
// or points) goes straight to the staging register and then to the output register.
// A full control cycle runs through one shift-add multiplier, a radix-4 square root and
// a restoring divider, one bit per cycle each: two gain products, two squares and the
// root, and, when the magnitude clamp applies, two more products and two divisions.
// One request is processed at a time; the input is ready whenever the sequencer idles.
// A finished word is held in a staging register while the output register is full, so
// a stalled receiver holds back at most one request. Reset clears the configuration to
// its defaults, the previous command and the cycle counter, and empties the output.
module repulsive_velocity_limiter
  import rvl_pkg::*;
#(
  parameter int VEL_WIDTH   = 16,
  parameter int FORCE_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // force_x, force_y, clearance, footprint_ok, scan_ok, points_present
  input  logic [((2*FORCE_WIDTH+CLR_W+3+7)/8)*8-1:0]    in_tdata,
  // req_type
  input  logic                                          in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // cmd_x, cmd_y, cmd_valid, status
  output logic [((2*VEL_WIDTH+1+STATUS_W+7)/8)*8-1:0]   out_tdata,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]                          cfg_index,
  input  logic [CFG_DATA_W-1:0]                         cfg_data
);

  localparam int OUT_DATA_W = ((2*VEL_WIDTH+1+STATUS_W+7)/8)*8;
  localparam int FY_LSB  = FORCE_WIDTH;
  localparam int CLR_LSB = 2*FORCE_WIDTH;
  localparam int FP_BIT  = CLR_LSB + CLR_W;
  localparam int SC_BIT  = FP_BIT + 1;
  localparam int PT_BIT  = FP_BIT + 2;

  localparam int MC_W   = (FORCE_WIDTH > TGT_W) ? FORCE_WIDTH : TGT_W;
  localparam int MP_W   = TGT_W;
  localparam int PW     = MC_W + 1 + MP_W;
  localparam int GP_W   = FORCE_WIDTH + GAIN_W;
  localparam int SH_W   = GP_W + 1 - TGT_SHIFT;
  localparam int EXT_W  = (SH_W > TGT_W) ? SH_W : TGT_W;
  localparam int CP_W   = TGT_W + SPEED_W;
  localparam int NUM_W  = CP_W + 1;
  localparam int RT_W   = TGT_W + 1;
  localparam int RAD_W  = 2 * RT_W;
  localparam int RM_W   = RT_W + 2;
  localparam int Q_W    = SPEED_W + 1;
  localparam int STEP_W = $clog2(RT_W + 1);
  localparam int SLW    = ((VEL_WIDTH > TGT_W + 1) ? VEL_WIDTH : TGT_W + 1) + 2;

  localparam logic signed [SLW-1:0] VMAX = SLW'({1'b0, {(VEL_WIDTH-1){1'b1}}});
  localparam logic signed [SLW-1:0] VMIN = ~VMAX;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_GX = 4'd1;
  localparam logic [3:0] S_MUL_GY = 4'd2;
  localparam logic [3:0] S_SQ_X   = 4'd3;
  localparam logic [3:0] S_SQ_Y   = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_MUL_CX = 4'd6;
  localparam logic [3:0] S_DIV_X  = 4'd7;
  localparam logic [3:0] S_MUL_CY = 4'd8;
  localparam logic [3:0] S_DIV_Y  = 4'd9;
  localparam logic [3:0] S_SLEW   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  function automatic logic [FORCE_WIDTH-1:0] abs_force(input logic [FORCE_WIDTH-1:0] f);
    abs_force = f[FORCE_WIDTH-1] ? (~f + 1'b1) : f;
  endfunction

  function automatic logic [VEL_WIDTH-1:0] slew(input logic [TGT_W-1:0] mag,
                                                input logic neg,
                                                input logic signed [VEL_WIDTH-1:0] last,
                                                input logic [SPEED_W-1:0] step);
    logic signed [SLW-1:0] t;
    logic signed [SLW-1:0] l;
    logic signed [SLW-1:0] a;
    logic signed [SLW-1:0] d;
    logic signed [SLW-1:0] v;
    t = SLW'(mag);
    if (neg) begin
      t = -t;
    end
    l = SLW'(last);
    a = SLW'(step);
    d = t - l;
    if (d > a) begin
      d = a;
    end
    if (d < -a) begin
      d = -a;
    end
    v = l + d;
    if (v > VMAX) begin
      v = VMAX;
    end
    if (v < VMIN) begin
      v = VMIN;
    end
    slew = v[VEL_WIDTH-1:0];
  endfunction

  logic [3:0]                   state_r, state_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic [GAIN_W-1:0]            gain_r, gain_nxt;
  logic [SPEED_W-1:0]           speed_r, speed_nxt;
  logic [SPEED_W-1:0]           accel_r, accel_nxt;
  logic [CLR_W-1:0]             thr_r, thr_nxt;
  logic [CYC_W-1:0]             tmo_r, tmo_nxt;
  logic signed [VEL_WIDTH-1:0]  last_x_r, last_x_nxt;
  logic signed [VEL_WIDTH-1:0]  last_y_r, last_y_nxt;
  logic [CYC_W-1:0]             cyc_r, cyc_nxt;
  logic [FORCE_WIDTH-1:0]       fmy_r, fmy_nxt;
  logic                         nx_r, nx_nxt;
  logic                         ny_r, ny_nxt;
  logic [CLR_W-1:0]             clr_r, clr_nxt;
  logic [TGT_W-1:0]             tx_r, tx_nxt;
  logic [TGT_W-1:0]             ty_r, ty_nxt;
  logic [MC_W-1:0]              mcand_r, mcand_nxt;
  logic [PW-1:0]                prod_r, prod_nxt;
  logic [RAD_W-1:0]             rad_r, rad_nxt;
  logic [RT_W-1:0]              root_r, root_nxt;
  logic [RM_W-1:0]              rem_r, rem_nxt;
  logic [RT_W-1:0]              drem_r, drem_nxt;
  logic [Q_W-1:0]               dq_r, dq_nxt;
  logic [VEL_WIDTH-1:0]         res_x_r, res_x_nxt;
  logic [VEL_WIDTH-1:0]         res_y_r, res_y_nxt;
  logic                         res_v_r, res_v_nxt;
  status_t                      res_st_r, res_st_nxt;
  logic                         out_v_r, out_v_nxt;
  logic [VEL_WIDTH-1:0]         ocx_r, ocx_nxt;
  logic [VEL_WIDTH-1:0]         ocy_r, ocy_nxt;
  logic                         ov_r, ov_nxt;
  status_t                      ost_r, ost_nxt;

  logic                         in_acc;
  logic [FORCE_WIDTH-1:0]       in_fx;
  logic [FORCE_WIDTH-1:0]       in_fy;
  logic                         in_fp;
  logic                         in_sc;
  logic                         in_pt;
  logic [CYC_W-1:0]             cyc_inc;

  logic [MC_W:0]                mul_hi;
  logic [PW-1:0]                mul_step;
  logic [GP_W-1:0]              gprod;
  logic [GP_W:0]                grnd;
  logic [EXT_W-1:0]             gext;
  logic [TGT_W-1:0]             tgt_mag;
  logic [2*TGT_W-1:0]           sq;
  logic [CP_W-1:0]              cprod;
  logic [NUM_W-1:0]             num;

  logic [RM_W+1:0]              rsh;
  logic [RM_W+1:0]              trial;
  logic                         sq_ge;
  logic                         clamp;
  logic [RT_W:0]                dsh;
  logic [RT_W:0]                dsub;
  logic                         dge;
  logic [VEL_WIDTH-1:0]         new_x;
  logic [VEL_WIDTH-1:0]         new_y;
  logic                         success;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({ost_r, ov_r, ocy_r, ocx_r});

  assign in_fx = in_tdata[FORCE_WIDTH-1:0];
  assign in_fy = in_tdata[FY_LSB +: FORCE_WIDTH];
  assign in_fp = in_tdata[FP_BIT];
  assign in_sc = in_tdata[SC_BIT];
  assign in_pt = in_tdata[PT_BIT];
  assign cyc_inc = (cyc_r == CYC_MAX) ? cyc_r : cyc_r + 1'b1;

  // Shift-add multiplier, multiplier bits consumed from the low end.
  assign mul_hi   = prod_r[PW-1:MP_W] + (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign mul_step = {mul_hi, prod_r[MP_W-1:0]} >> 1;

  assign gprod   = prod_r[MP_W-GAIN_W +: GP_W];
  assign grnd    = {1'b0, gprod} + (GP_W+1)'(1 << (TGT_SHIFT-1));
  assign gext    = EXT_W'(grnd[GP_W:TGT_SHIFT]);
  assign tgt_mag = (gext > EXT_W'(TGT_MAX)) ? TGT_MAX : gext[TGT_W-1:0];
  assign sq      = prod_r[2*TGT_W-1:0];
  assign cprod   = prod_r[MP_W-SPEED_W +: CP_W];
  assign num     = NUM_W'(cprod) + NUM_W'(root_r >> 1);

  assign rsh   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (RM_W+2)'({root_r, 2'b01});
  assign sq_ge = (rsh >= trial);
  assign clamp = (root_r > RT_W'(speed_r)) ||
                 ((root_r == RT_W'(speed_r)) && (rem_r != '0));

  assign dsh  = {drem_r, dq_r[Q_W-1]};
  assign dsub = {1'b0, root_r};
  assign dge  = (dsh >= dsub);

  assign new_x   = slew(tx_r, nx_r, last_x_r, accel_r);
  assign new_y   = slew(ty_r, ny_r, last_y_r, accel_r);
  assign success = (clr_r == CLR_NONE) || (clr_r > thr_r);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    gain_nxt   = gain_r;
    speed_nxt  = speed_r;
    accel_nxt  = accel_r;
    thr_nxt    = thr_r;
    tmo_nxt    = tmo_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    cyc_nxt    = cyc_r;
    fmy_nxt    = fmy_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    clr_nxt    = clr_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    mcand_nxt  = mcand_r;
    prod_nxt   = prod_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    drem_nxt   = drem_r;
    dq_nxt     = dq_r;
    res_x_nxt  = res_x_r;
    res_y_nxt  = res_y_r;
    res_v_nxt  = res_v_r;
    res_st_nxt = res_st_r;
    out_v_nxt  = out_v_r;
    ocx_nxt    = ocx_r;
    ocy_nxt    = ocy_r;
    ov_nxt     = ov_r;
    ost_nxt    = ost_r;

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FORCE_GAIN: gain_nxt  = cfg_data;
        CFG_MAX_SPEED:  speed_nxt = cfg_data[SPEED_W-1:0];
        CFG_ACCEL_STEP: accel_nxt = cfg_data[SPEED_W-1:0];
        CFG_CLR_THRESH: thr_nxt   = cfg_data;
        CFG_TIMEOUT:    tmo_nxt   = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_x_nxt = '0;
          res_y_nxt = '0;
          state_nxt = S_DONE;
          if (!in_tuser) begin
            last_x_nxt = '0;
            last_y_nxt = '0;
            cyc_nxt    = '0;
            res_v_nxt  = 1'b0;
            res_st_nxt = !in_fp ? ST_NO_FOOTPRINT : (!in_sc ? ST_NO_SCAN : ST_RUNNING);
          end else begin
            cyc_nxt = cyc_inc;
            if (cyc_inc > tmo_r) begin
              res_v_nxt  = 1'b1;
              res_st_nxt = ST_TIMEOUT;
            end else if (!in_fp) begin
              res_v_nxt  = 1'b1;
              res_st_nxt = ST_NO_FOOTPRINT;
            end else if (!in_sc) begin
              res_v_nxt  = 1'b1;
              res_st_nxt = ST_NO_SCAN;
            end else if (!in_pt) begin
              res_v_nxt  = 1'b0;
              res_st_nxt = ST_RUNNING;
            end else begin
              nx_nxt    = in_fx[FORCE_WIDTH-1];
              ny_nxt    = in_fy[FORCE_WIDTH-1];
              fmy_nxt   = abs_force(in_fy);
              clr_nxt   = in_tdata[CLR_LSB +: CLR_W];
              mcand_nxt = MC_W'(abs_force(in_fx));
              prod_nxt  = PW'(gain_r);
              step_nxt  = STEP_W'(GAIN_W);
              state_nxt = S_MUL_GX;
            end
          end
        end
      end
      S_MUL_GX, S_MUL_GY, S_SQ_X, S_SQ_Y, S_MUL_CX, S_MUL_CY: begin
        if (step_r != '0) begin
          prod_nxt = mul_step;
          step_nxt = step_r - 1'b1;
        end else begin
          unique case (state_r)
            S_MUL_GX: begin
              tx_nxt    = tgt_mag;
              mcand_nxt = MC_W'(fmy_r);
              prod_nxt  = PW'(gain_r);
              step_nxt  = STEP_W'(GAIN_W);
              state_nxt = S_MUL_GY;
            end
            S_MUL_GY: begin
              ty_nxt    = tgt_mag;
              mcand_nxt = MC_W'(tx_r);
              prod_nxt  = PW'(tx_r);
              step_nxt  = STEP_W'(TGT_W);
              state_nxt = S_SQ_X;
            end
            S_SQ_X: begin
              rad_nxt   = RAD_W'(sq);
              mcand_nxt = MC_W'(ty_r);
              prod_nxt  = PW'(ty_r);
              step_nxt  = STEP_W'(TGT_W);
              state_nxt = S_SQ_Y;
            end
            S_SQ_Y: begin
              rad_nxt   = rad_r + RAD_W'(sq);
              root_nxt  = '0;
              rem_nxt   = '0;
              step_nxt  = STEP_W'(RT_W);
              state_nxt = S_SQRT;
            end
            S_MUL_CX: begin
              drem_nxt  = RT_W'(num[NUM_W-1:Q_W]);
              dq_nxt    = num[Q_W-1:0];
              step_nxt  = STEP_W'(Q_W);
              state_nxt = S_DIV_X;
            end
            default: begin
              drem_nxt  = RT_W'(num[NUM_W-1:Q_W]);
              dq_nxt    = num[Q_W-1:0];
              step_nxt  = STEP_W'(Q_W);
              state_nxt = S_DIV_Y;
            end
          endcase
        end
      end
      S_SQRT: begin
        if (step_r != '0) begin
          rem_nxt  = sq_ge ? RM_W'(rsh - trial) : rsh[RM_W-1:0];
          root_nxt = {root_r[RT_W-2:0], sq_ge};
          rad_nxt  = rad_r << 2;
          step_nxt = step_r - 1'b1;
        end else if (clamp) begin
          mcand_nxt = MC_W'(tx_r);
          prod_nxt  = PW'(speed_r);
          step_nxt  = STEP_W'(SPEED_W);
          state_nxt = S_MUL_CX;
        end else begin
          state_nxt = S_SLEW;
        end
      end
      S_DIV_X, S_DIV_Y: begin
        if (step_r != '0) begin
          drem_nxt = dge ? RT_W'(dsh - dsub) : dsh[RT_W-1:0];
          dq_nxt   = {dq_r[Q_W-2:0], dge};
          step_nxt = step_r - 1'b1;
        end else if (state_r == S_DIV_X) begin
          tx_nxt    = TGT_W'(dq_r);
          mcand_nxt = MC_W'(ty_r);
          prod_nxt  = PW'(speed_r);
          step_nxt  = STEP_W'(SPEED_W);
          state_nxt = S_MUL_CY;
        end else begin
          ty_nxt    = TGT_W'(dq_r);
          state_nxt = S_SLEW;
        end
      end
      S_SLEW: begin
        res_v_nxt = 1'b1;
        if (success) begin
          last_x_nxt = '0;
          last_y_nxt = '0;
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          res_st_nxt = ST_SUCCEEDED;
        end else begin
          last_x_nxt = new_x;
          last_y_nxt = new_y;
          res_x_nxt  = new_x;
          res_y_nxt  = new_y;
          res_st_nxt = ST_RUNNING;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          ocx_nxt   = res_x_r;
          ocy_nxt   = res_y_r;
          ov_nxt    = res_v_r;
          ost_nxt   = res_st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      out_v_r  <= 1'b0;
      gain_r   <= RST_FORCE_GAIN;
      speed_r  <= RST_MAX_SPEED;
      accel_r  <= RST_ACCEL_STEP;
      thr_r    <= RST_CLR_THRESH;
      tmo_r    <= RST_TIMEOUT;
      last_x_r <= '0;
      last_y_r <= '0;
      cyc_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      gain_r   <= gain_nxt;
      speed_r  <= speed_nxt;
      accel_r  <= accel_nxt;
      thr_r    <= thr_nxt;
      tmo_r    <= tmo_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      cyc_r    <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    fmy_r    <= fmy_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    clr_r    <= clr_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    mcand_r  <= mcand_nxt;
    prod_r   <= prod_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    drem_r   <= drem_nxt;
    dq_r     <= dq_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    res_v_r  <= res_v_nxt;
    res_st_r <= res_st_nxt;
    ocx_r    <= ocx_nxt;
    ocy_r    <= ocy_nxt;
    ov_r     <= ov_nxt;
    ost_r    <= ost_nxt;
  end

endmodule

@@ tb/repulsive_velocity_limiter_test.sv @@
module repulsive_velocity_limiter_test
  import rvl_pkg::*;
();

  localparam int VEL_W     = 16;
  localparam int FORCE_W   = 32;
  localparam int IN_W      = ((2*FORCE_W+CLR_W+3+7)/8)*8;
  localparam int OUT_W     = ((2*VEL_W+1+STATUS_W+7)/8)*8;
  localparam int STALL_MAX = 5000;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_CYCLE = 1'b1;

  typedef struct {
    logic                      kind;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic [CLR_W-1:0]          clearance;
    logic                      fp_ok;
    logic                      scan_ok;
    logic                      pts_ok;
  } request_t;

  typedef struct {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    issued;
    status_t                 status;
  } command_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [GAIN_W-1:0]       gain_q;
  logic [SPEED_W-1:0]      speed_lim;
  logic [SPEED_W-1:0]      accel_lim;
  logic [CLR_W-1:0]        clr_thresh;
  logic [CYC_W-1:0]        timeout_lim;
  logic signed [VEL_W-1:0] prev_vx;
  logic signed [VEL_W-1:0] prev_vy;
  logic [CYC_W-1:0]        run_cycles;

  request_t pending_requests[$];
  command_t expected_cmds[$];
  request_t in_flight;
  command_t want;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;
  int       stall_cycles = 0;

  repulsive_velocity_limiter #(
    .VEL_WIDTH  (VEL_W),
    .FORCE_WIDTH(FORCE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r + (longint'(1) << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic longint scale_axis(logic signed [FORCE_W-1:0] f);
    longint fv;
    longint mag;
    fv  = longint'(f);
    mag = (fv < 0) ? -fv : fv;
    mag = (mag * longint'(gain_q) + (longint'(1) << (TGT_SHIFT - 1))) >> TGT_SHIFT;
    if (mag > longint'(TGT_MAX)) mag = longint'(TGT_MAX);
    return (fv < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [VEL_W-1:0] slew_axis(longint target,
                                                         logic signed [VEL_W-1:0] prev);
    longint d;
    longint v;
    d = target - longint'(prev);
    if (d > longint'(accel_lim)) d = longint'(accel_lim);
    if (d < -longint'(accel_lim)) d = -longint'(accel_lim);
    v = longint'(prev) + d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VEL_W-1:0];
  endfunction

  function automatic command_t compute_command(request_t r);
    command_t c;
    longint   tx, ty, mx, my, lim, sum, root;
    c.vx     = '0;
    c.vy     = '0;
    c.issued = 1'b0;
    c.status = ST_RUNNING;
    if (r.kind == REQ_START) begin
      prev_vx    = '0;
      prev_vy    = '0;
      run_cycles = '0;
      if (!r.fp_ok) c.status = ST_NO_FOOTPRINT;
      else if (!r.scan_ok) c.status = ST_NO_SCAN;
      return c;
    end
    if (run_cycles != CYC_MAX) run_cycles = run_cycles + 1'b1;
    if (run_cycles > timeout_lim) begin
      c.issued = 1'b1;
      c.status = ST_TIMEOUT;
      return c;
    end
    if (!r.fp_ok || !r.scan_ok) begin
      c.issued = 1'b1;
      c.status = r.fp_ok ? ST_NO_SCAN : ST_NO_FOOTPRINT;
      return c;
    end
    if (!r.pts_ok) return c;
    tx  = scale_axis(r.fx);
    ty  = scale_axis(r.fy);
    mx  = (tx < 0) ? -tx : tx;
    my  = (ty < 0) ? -ty : ty;
    lim = longint'(speed_lim);
    sum = mx * mx + my * my;
    if (sum > lim * lim) begin
      root = floor_sqrt(sum);
      mx   = (mx * lim + root / 2) / root;
      my   = (my * lim + root / 2) / root;
      tx   = (tx < 0) ? -mx : mx;
      ty   = (ty < 0) ? -my : my;
    end
    prev_vx  = slew_axis(tx, prev_vx);
    prev_vy  = slew_axis(ty, prev_vy);
    c.issued = 1'b1;
    if (r.clearance == CLR_NONE || r.clearance > clr_thresh) begin
      prev_vx  = '0;
      prev_vy  = '0;
      c.status = ST_SUCCEEDED;
    end else begin
      c.vx = prev_vx;
      c.vy = prev_vy;
    end
    return c;
  endfunction

  function automatic request_t make_req(logic kind, logic signed [FORCE_W-1:0] fx,
                                        logic signed [FORCE_W-1:0] fy,
                                        int clr, int fp, int sc, int pts);
    request_t r;
    r.kind      = kind;
    r.fx        = fx;
    r.fy        = fy;
    r.clearance = CLR_W'(clr);
    r.fp_ok     = fp[0];
    r.scan_ok   = sc[0];
    r.pts_ok    = pts[0];
    return r;
  endfunction

  function automatic logic signed [FORCE_W-1:0] random_force();
    logic signed [FORCE_W-1:0] f;
    int unsigned               pick;
    pick = $urandom_range(0, 19);
    f    = $urandom;
    if (pick == 0) f = 32'sh7fffffff;
    else if (pick == 1) f = 32'sh80000000;
    else if (pick == 2) f = '0;
    else f = f >>> $urandom_range(0, 31);
    return f;
  endfunction

  function automatic request_t random_request();
    return make_req(1'($urandom_range(0, 1)), random_force(), random_force(),
                    $urandom_range(0, 65535), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  function automatic request_t run_start();
    request_t r;
    r      = random_request();
    r.kind = REQ_START;
    if ($urandom_range(0, 99) < 85) begin
      r.fp_ok   = 1'b1;
      r.scan_ok = 1'b1;
    end
    return r;
  endfunction

  function automatic request_t run_cycle();
    request_t    r;
    int unsigned pick;
    r      = random_request();
    r.kind = REQ_CYCLE;
    if ($urandom_range(0, 99) < 90) begin
      r.fp_ok   = 1'b1;
      r.scan_ok = 1'b1;
      r.pts_ok  = 1'b1;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) r.clearance = CLR_NONE;
    else if (pick > 1) r.clearance = CLR_W'($urandom_range(0, clr_thresh));
    return r;
  endfunction

  task automatic queue_request(input request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_random_traffic(int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(random_request());
        added++;
      end else begin
        len = $urandom_range(1, 40);
        queue_request(run_start());
        for (int i = 0; i < len; i++) queue_request(run_cycle());
        added += len + 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FORCE_GAIN: gain_q      = val;
      CFG_MAX_SPEED:  speed_lim   = val[SPEED_W-1:0];
      CFG_ACCEL_STEP: accel_lim   = val[SPEED_W-1:0];
      CFG_CLR_THRESH: clr_thresh  = val;
      CFG_TIMEOUT:    timeout_lim = val;
      default: ;
    endcase
  endtask

  task automatic program_limits(input int gain, input int speed, input int accel,
                                input int thresh, input int tmo);
    write_register(CFG_FORCE_GAIN, CFG_DATA_W'(gain));
    write_register(CFG_MAX_SPEED, CFG_DATA_W'(speed));
    write_register(CFG_ACCEL_STEP, CFG_DATA_W'(accel));
    write_register(CFG_CLR_THRESH, CFG_DATA_W'(thresh));
    write_register(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    cfg_valid <= 1'b0;
  endtask

  task automatic program_moderate();
    program_limits($urandom_range(1000, 65535), $urandom_range(256, 8192),
                   $urandom_range(50, 3000), $urandom_range(500, 8000),
                   $urandom_range(1, 50));
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random_traffic(count);
    wait_drained();
  endtask

  task automatic check_field(input string name, input longint exp_val, input longint got_val);
    if (exp_val != got_val) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_cmds.insert(expected_cmds.size(), compute_command(in_flight));
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, in_flight.pts_ok, in_flight.scan_ok, in_flight.fp_ok,
                        in_flight.clearance, in_flight.fy, in_flight.fx};
          in_tuser  <= in_flight.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("cmd_x", longint'(want.vx), longint'($signed(out_tdata[15:0])));
          check_field("cmd_y", longint'(want.vy), longint'($signed(out_tdata[31:16])));
          check_field("cmd_valid", longint'(want.issued), longint'(out_tdata[32]));
          check_field("status", longint'(want.status), longint'(out_tdata[35:33]));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (pending_requests.size() == 0 && !in_tvalid && expected_cmds.size() == 0
            && !cfg_valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("repulsive_velocity_limiter: mismatch");
      $finish;
    end
  end

  initial begin
    gain_q      = RST_FORCE_GAIN;
    speed_lim   = RST_MAX_SPEED;
    accel_lim   = RST_ACCEL_STEP;
    clr_thresh  = RST_CLR_THRESH;
    timeout_lim = RST_TIMEOUT;
    prev_vx     = '0;
    prev_vy     = '0;
    run_cycles  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: start outcomes, stop priorities, clamp, slew and success.
    queue_request(make_req(REQ_START, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(REQ_START, -1, 1, 65535, 0, 1, 1));
    queue_request(make_req(REQ_START, 0, 0, 0, 1, 0, 1));
    queue_request(make_req(REQ_START, 0, 0, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 32'sh7fffffff, 0, 0, 0, 1, 1));
    queue_request(make_req(REQ_CYCLE, 32'sh7fffffff, 0, 0, 1, 0, 1));
    queue_request(make_req(REQ_CYCLE, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(REQ_CYCLE, 32'sh7fffffff, 0, 0, 1, 1, 0));
    queue_request(make_req(REQ_CYCLE, 32'sh7fffffff, 0, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 32'sh7fffffff, 32'sh80000000, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 32'sh80000000, 32'sh80000000, 1434, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 160000, -80000, 100, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 0, 0, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 0, 0, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, -1, 1, 0, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, 80000, 80000, 1435, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, -80000, 80000, 65535, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, -160000, -160000, 65534, 1, 1, 1));
    queue_request(make_req(REQ_CYCLE, -160000, 160000, 0, 1, 1, 1));
    queue_request(make_req(REQ_START, 0, 0, 65535, 1, 1, 0));
    queue_request(make_req(REQ_CYCLE, 1000000, -1000000, 0, 1, 1, 1));
    wait_drained();

    program_moderate();
    run_phase(65, 0, 120);
    program_limits(65535, 32767, 32767, 65535, 65535);
    run_phase(0, 65, 100);
    program_limits(65535, 0, 32767, 0, 65535);
    run_phase(16, 16, 50);
    program_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
    run_phase(0, 0, 120);
    program_moderate();
    run_phase(65, 0, 120);
    program_moderate();
    run_phase(0, 65, 120);
    program_limits(0, 0, 0, 0, 0);
    run_phase(16, 16, 50);

    repeat (250) @(posedge clk);
    if (mismatches == 0) begin
      $display("repulsive_velocity_limiter: match");
    end else begin
      $display("repulsive_velocity_limiter: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rvl_pkg.sv
hw/rtl/repulsive_velocity_limiter.sv
tb/repulsive_velocity_limiter_test.sv
